>>> sv/i2p_pkg.sv
package i2p_pkg;

  // Character codes
  localparam logic [7:0] CH_OPEN_P  = 8'h28; // (
  localparam logic [7:0] CH_OPEN_C  = 8'h7B; // {
  localparam logic [7:0] CH_OPEN_S  = 8'h5B; // [
  localparam logic [7:0] CH_CLOSE_P = 8'h29; // )
  localparam logic [7:0] CH_CLOSE_C = 8'h7D; // }
  localparam logic [7:0] CH_CLOSE_S = 8'h5D; // ]
  localparam logic [7:0] CH_PLUS    = 8'h2B; // +
  localparam logic [7:0] CH_MINUS   = 8'h2D; // -
  localparam logic [7:0] CH_STAR    = 8'h2A; // *
  localparam logic [7:0] CH_SLASH   = 8'h2F; // /
  localparam logic [7:0] CH_OPND_LO = 8'h41; // A
  localparam logic [7:0] CH_OPND_HI = 8'h7A; // z

  // Status codes on the end item
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNM_CLOSE = 2'd2;
  localparam logic [1:0] STAT_UNM_OPEN  = 2'd3;

  // Stack commands from the sequencer
  typedef struct packed {
    logic push;
    logic pop;
    logic rd;
  } stk_cmd_t;

  // Stack status back to the sequencer
  typedef struct packed {
    logic empty;
    logic full;
  } stk_stat_t;

  function automatic logic is_open(input logic [7:0] c);
    return (c == CH_OPEN_P) || (c == CH_OPEN_C) || (c == CH_OPEN_S);
  endfunction

  function automatic logic is_close(input logic [7:0] c);
    return (c == CH_CLOSE_P) || (c == CH_CLOSE_C) || (c == CH_CLOSE_S);
  endfunction

  function automatic logic is_op(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  function automatic logic is_operand(input logic [7:0] c);
    return (c >= CH_OPND_LO) && (c <= CH_OPND_HI);
  endfunction

  // High precedence: * and /
  function automatic logic is_hi_rank(input logic [7:0] c);
    return (c == CH_STAR) || (c == CH_SLASH);
  endfunction

endpackage

>>> sv/i2p_stack.sv
module i2p_stack #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  i2p_pkg::stk_cmd_t  cmd,
  input  logic [7:0]         wdata,
  output i2p_pkg::stk_stat_t stat,
  output logic [7:0]         rd_data
);
  import i2p_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [7:0]    mem [DEPTH];
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;
  logic [CW-1:0] top_idx;

  assign top_idx    = cnt_r - CW'(1);
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == FULL_CNT);

  // Shared up/down pointer unit
  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.push && !stat.full) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (cmd.pop && !stat.empty) begin
      cnt_nxt = top_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage, registered read of the top entry
  always_ff @(posedge clk) begin
    if (cmd.push && !stat.full) begin
      mem[cnt_r[AW-1:0]] <= wdata;
    end
    if (cmd.rd) begin
      rd_data <= mem[top_idx[AW-1:0]];
    end
  end

endmodule

>>> sv/infix_to_postfix_converter.sv
// Steps: an operand or an ignored character passes through idle and flush; each
// stack entry examined by an operator, a close bracket or the final drain adds
// a top-of-stack read, then an evaluate, as the stack read port is registered.
// A check that finds the stack empty adds a read only; a final character adds a
// drain start and its empty check. Output back-pressure stalls evaluate and flush.
// Throughput: one character at a time; a new one is taken only in idle.
// Reset (rst_n, synchronous, active low) empties the stack, clears the error
// code, the hold slot and the output valid flag; stack contents are not cleared.
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_symbol,
  input  logic       in_last_of_expr,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_symbol,
  output logic       out_has_symbol,
  output logic       out_end_of_expr,
  output logic [1:0] out_status
);
  import i2p_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FLUSH
  } state_t;

  typedef enum logic [1:0] {
    M_NONE,
    M_CLOSE,
    M_OP,
    M_DRAIN
  } mode_t;

  state_t     state_r, state_nxt;
  mode_t      mode_r, mode_nxt;
  logic [7:0] sym_r, sym_nxt;
  logic       last_r, last_nxt;
  logic [1:0] err_r, err_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       hold_v_r, hold_v_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] osym_r, osym_nxt;
  logic       ohas_r, ohas_nxt;
  logic       oend_r, oend_nxt;
  logic [1:0] ostat_r, ostat_nxt;

  stk_cmd_t   cmd;
  stk_stat_t  stat;
  logic [7:0] wdata;
  logic [7:0] top;
  logic       out_free;
  logic       emit_ok;

  i2p_stack #(.DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .wdata   (wdata),
    .stat    (stat),
    .rd_data (top)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = ov_r;
  assign out_symbol      = osym_r;
  assign out_has_symbol  = ohas_r;
  assign out_end_of_expr = oend_r;
  assign out_status      = ostat_r;

  assign wdata    = (state_r == S_IDLE) ? in_symbol : sym_r;
  assign out_free = !ov_r || out_ready;
  // a new character goes to the hold slot; an older one moves to the output
  assign emit_ok  = !hold_v_r || out_free;

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    sym_nxt    = sym_r;
    last_nxt   = last_r;
    err_nxt    = err_r;
    hold_nxt   = hold_r;
    hold_v_nxt = hold_v_r;
    ov_nxt     = ov_r && !out_ready;
    osym_nxt   = osym_r;
    ohas_nxt   = ohas_r;
    oend_nxt   = oend_r;
    ostat_nxt  = ostat_r;
    cmd        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          sym_nxt  = in_symbol;
          last_nxt = in_last_of_expr;
          mode_nxt = M_NONE;
          if (is_open(in_symbol)) begin
            cmd.push = 1'b1;
            if (stat.full && err_r == STAT_OK) err_nxt = STAT_OVERFLOW;
            state_nxt = S_FLUSH;
          end else if (is_close(in_symbol)) begin
            mode_nxt  = M_CLOSE;
            state_nxt = S_READ;
          end else if (is_op(in_symbol)) begin
            mode_nxt  = M_OP;
            state_nxt = S_READ;
          end else if (is_operand(in_symbol)) begin
            hold_nxt   = in_symbol;
            hold_v_nxt = 1'b1;
            state_nxt  = S_FLUSH;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_READ: begin
        if (stat.empty) begin
          if (mode_r == M_CLOSE && err_r == STAT_OK) err_nxt = STAT_UNM_CLOSE;
          if (mode_r == M_OP) cmd.push = 1'b1;
          state_nxt = S_FLUSH;
        end else begin
          cmd.rd    = 1'b1;
          state_nxt = S_EVAL;
        end
      end

      S_EVAL: begin
        case (mode_r)
          M_CLOSE: begin
            if (is_open(top)) begin
              cmd.pop   = 1'b1;
              state_nxt = S_FLUSH;
            end else if (emit_ok) begin
              cmd.pop   = 1'b1;
              state_nxt = S_READ;
            end
          end
          M_OP: begin
            if (is_open(top) || (!is_hi_rank(top) && is_hi_rank(sym_r))) begin
              cmd.push = 1'b1;
              if (stat.full && err_r == STAT_OK) err_nxt = STAT_OVERFLOW;
              state_nxt = S_FLUSH;
            end else if (emit_ok) begin
              cmd.pop   = 1'b1;
              state_nxt = S_READ;
            end
          end
          M_DRAIN: begin
            if (is_open(top)) begin
              cmd.pop = 1'b1;
              if (err_r == STAT_OK) err_nxt = STAT_UNM_OPEN;
              state_nxt = S_READ;
            end else if (emit_ok) begin
              cmd.pop   = 1'b1;
              state_nxt = S_READ;
            end
          end
          default: begin
            state_nxt = S_FLUSH;
          end
        endcase
        // emitted character: previous hold moves out, top enters hold
        if (cmd.pop && !is_open(top)) begin
          if (hold_v_r) begin
            ov_nxt    = 1'b1;
            osym_nxt  = hold_r;
            ohas_nxt  = 1'b1;
            oend_nxt  = 1'b0;
            ostat_nxt = STAT_OK;
          end
          hold_nxt   = top;
          hold_v_nxt = 1'b1;
        end
      end

      S_FLUSH: begin
        if (last_r && mode_r != M_DRAIN) begin
          mode_nxt  = M_DRAIN;
          state_nxt = S_READ;
        end else if (last_r) begin
          // end item: last character or an empty item, with status
          if (out_free) begin
            ov_nxt     = 1'b1;
            osym_nxt   = hold_v_r ? hold_r : 8'h00;
            ohas_nxt   = hold_v_r;
            oend_nxt   = 1'b1;
            ostat_nxt  = err_r;
            err_nxt    = STAT_OK;
            hold_v_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end else if (hold_v_r) begin
          if (out_free) begin
            ov_nxt     = 1'b1;
            osym_nxt   = hold_r;
            ohas_nxt   = 1'b1;
            oend_nxt   = 1'b0;
            ostat_nxt  = STAT_OK;
            hold_v_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= M_NONE;
      err_r    <= STAT_OK;
      hold_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      err_r    <= err_nxt;
      hold_v_r <= hold_v_nxt;
      ov_r     <= ov_nxt;
    end
    sym_r   <= sym_nxt;
    last_r  <= last_nxt;
    hold_r  <= hold_nxt;
    osym_r  <= osym_nxt;
    ohas_r  <= ohas_nxt;
    oend_r  <= oend_nxt;
    ostat_r <= ostat_nxt;
  end

  // Assertions
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !hold_v_r)
    else $error("hold slot occupied while idle");

  a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> ($past(state_r) == S_READ || $past(state_r) == S_EVAL))
    else $error("evaluate without a stack read");

  a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_symbol) |-> (out_end_of_expr && out_symbol == 8'h00))
    else $error("empty result that is not an end item");

  a_status_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_end_of_expr) |-> (out_status == STAT_OK))
    else $error("status on a non-end result");

endmodule

>>> test/infix_to_postfix_converter_tb.sv
`timescale 1ns / 1ps

module infix_to_postfix_converter_tb;
  import i2p_pkg::*;

  localparam int STK_DEPTH = 32;
  localparam int RAND_ITEMS = 200;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int TAIL_CYCLES = 200;

  typedef enum logic [2:0] {
    K_IGNORE,
    K_OPEN,
    K_CLOSE,
    K_OP,
    K_OPERAND
  } sym_kind_t;

  typedef struct {
    logic [7:0] sym;
    logic       last;
  } char_item_t;

  typedef struct {
    logic [7:0] sym;
    logic       has;
    logic       eoe;
    logic [1:0] st;
  } postfix_rec_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_symbol = 8'h00;
  logic       in_last_of_expr = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_symbol;
  logic       out_has_symbol;
  logic       out_end_of_expr;
  logic [1:0] out_status;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STK_DEPTH)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_symbol      (in_symbol),
    .in_last_of_expr(in_last_of_expr),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_symbol     (out_symbol),
    .out_has_symbol (out_has_symbol),
    .out_end_of_expr(out_end_of_expr),
    .out_status     (out_status)
  );

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  char_item_t   infix_q[$];
  postfix_rec_t postfix_q[$];
  int           mismatch_cnt = 0;

  // Shadow operator stack
  logic [7:0]  shadow_stk [0:STK_DEPTH-1];
  int unsigned shadow_cnt = 0;
  logic [1:0]  shadow_err = STAT_OK;
  int          step_emits;

  function automatic sym_kind_t classify(logic [7:0] c);
    case (c)
      CH_OPEN_P, CH_OPEN_C, CH_OPEN_S:    return K_OPEN;
      CH_CLOSE_P, CH_CLOSE_C, CH_CLOSE_S: return K_CLOSE;
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH: return K_OP;
      default: begin
        if (c >= CH_OPND_LO && c <= CH_OPND_HI) return K_OPERAND;
        return K_IGNORE;
      end
    endcase
  endfunction

  function automatic logic mul_div(logic [7:0] c);
    return (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  function automatic void note_err(logic [1:0] code);
    if (shadow_err == STAT_OK) shadow_err = code;
  endfunction

  function automatic void emit_sym(logic [7:0] c);
    postfix_rec_t r;
    r.sym = c;
    r.has = 1'b1;
    r.eoe = 1'b0;
    r.st  = STAT_OK;
    postfix_q.push_back(r);
    step_emits++;
  endfunction

  function automatic void push_op(logic [7:0] c);
    if (shadow_cnt >= STK_DEPTH) begin
      note_err(STAT_OVERFLOW);
    end else begin
      shadow_stk[shadow_cnt] = c;
      shadow_cnt++;
    end
  endfunction

  // Expected postfix output for one accepted character
  function automatic void predict_postfix(logic [7:0] sym, logic last);
    logic [7:0]   top;
    logic         matched;
    postfix_rec_t r;
    step_emits = 0;
    case (classify(sym))
      K_OPEN: push_op(sym);
      K_CLOSE: begin
        matched = 1'b0;
        while (shadow_cnt > 0 && !matched) begin
          shadow_cnt--;
          top = shadow_stk[shadow_cnt];
          if (classify(top) == K_OPEN) matched = 1'b1;
          else emit_sym(top);
        end
        if (!matched) note_err(STAT_UNM_CLOSE);
      end
      K_OP: begin
        // pop while top is an operator of equal or higher rank
        while (shadow_cnt > 0 && classify(shadow_stk[shadow_cnt-1]) != K_OPEN &&
               (mul_div(shadow_stk[shadow_cnt-1]) || !mul_div(sym))) begin
          shadow_cnt--;
          emit_sym(shadow_stk[shadow_cnt]);
        end
        push_op(sym);
      end
      K_OPERAND: emit_sym(sym);
      default: ;
    endcase
    if (last) begin
      while (shadow_cnt > 0) begin
        shadow_cnt--;
        top = shadow_stk[shadow_cnt];
        if (classify(top) == K_OPEN) note_err(STAT_UNM_OPEN);
        else emit_sym(top);
      end
      if (step_emits == 0) begin
        r.sym = 8'h00;
        r.has = 1'b0;
        postfix_q.push_back(r);
      end
      // end mark and status ride on the final record
      r = postfix_q.pop_back();
      r.eoe = 1'b1;
      r.st  = shadow_err;
      postfix_q.push_back(r);
      shadow_err = STAT_OK;
    end
  endfunction

  // Stimulus helpers
  function automatic void add_char(logic [7:0] c, logic last);
    char_item_t it;
    it.sym  = c;
    it.last = last;
    infix_q.push_back(it);
  endfunction

  function automatic void add_expr(string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i], i == s.len() - 1);
  endfunction

  function automatic void mark_last();
    char_item_t it;
    it = infix_q.pop_back();
    it.last = 1'b1;
    infix_q.push_back(it);
  endfunction

  function automatic logic [7:0] rand_open();
    case ($urandom_range(2))
      0:       return CH_OPEN_P;
      1:       return CH_OPEN_C;
      default: return CH_OPEN_S;
    endcase
  endfunction

  function automatic logic [7:0] rand_close();
    case ($urandom_range(2))
      0:       return CH_CLOSE_P;
      1:       return CH_CLOSE_C;
      default: return CH_CLOSE_S;
    endcase
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] rand_operand();
    logic [7:0] c;
    do c = 8'($urandom_range(CH_OPND_HI, CH_OPND_LO));
    while (classify(c) != K_OPERAND);
    return c;
  endfunction

  function automatic logic [7:0] rand_ignored();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (classify(c) != K_IGNORE);
    return c;
  endfunction

  // Nested opens with operators between them, past the stack depth
  function automatic void gen_overflow();
    int   n;
    logic prev_open;
    n = $urandom_range(STK_DEPTH + 8, STK_DEPTH + 1);
    prev_open = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (prev_open && $urandom_range(1) == 0) begin
        add_char(rand_op(), 1'b0);
        prev_open = 1'b0;
      end else begin
        add_char(rand_open(), 1'b0);
        prev_open = 1'b1;
      end
    end
    add_char(rand_operand(), 1'b1);
  endfunction

  // Balanced expression with random content and some ignored noise
  function automatic void gen_balanced();
    int   depth;
    int   ops_left;
    logic want_operand;
    logic done;
    depth = 0;
    ops_left = $urandom_range(7);
    want_operand = 1'b1;
    done = 1'b0;
    while (!done) begin
      if ($urandom_range(9) == 0) add_char(rand_ignored(), 1'b0);
      if (want_operand) begin
        if (depth < 6 && $urandom_range(3) == 0) begin
          add_char(rand_open(), 1'b0);
          depth++;
        end else begin
          add_char(rand_operand(), 1'b0);
          want_operand = 1'b0;
        end
      end else if (depth > 0 && $urandom_range(2) == 0) begin
        add_char(rand_close(), 1'b0);
        depth--;
      end else if (ops_left > 0) begin
        add_char(rand_op(), 1'b0);
        ops_left--;
        want_operand = 1'b1;
      end else if (depth > 0) begin
        add_char(rand_close(), 1'b0);
        depth--;
      end else begin
        done = 1'b1;
      end
    end
    if ($urandom_range(7) == 0) add_char(rand_ignored(), 1'b1);
    else mark_last();
  endfunction

  // Arbitrary character soup
  function automatic void gen_broken();
    int n;
    n = $urandom_range(10, 1);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0:       add_char(rand_open(), i == n - 1);
        1:       add_char(rand_close(), i == n - 1);
        2:       add_char(rand_op(), i == n - 1);
        3, 4:    add_char(rand_operand(), i == n - 1);
        default: add_char(8'($urandom_range(255)), i == n - 1);
      endcase
    end
  endfunction

  // Input driver: bursts of transfers separated by random gaps
  int gap_left = 0;
  int burst_left = 1;

  always @(posedge clk) begin
    char_item_t it;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_postfix(in_symbol, in_last_of_expr);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (infix_q.size() > 0) begin
          it = infix_q.pop_front();
          in_valid        <= 1'b1;
          in_symbol       <= it.sym;
          in_last_of_expr <= it.last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(24, 1);
            gap_left   <= ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic log_mismatch(string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Output monitor and ready pattern
  int          ready_mode = 0;
  int          mode_left = 0;
  logic [3:0]  stall_phase = 4'd0;

  always @(posedge clk) begin
    postfix_rec_t exp_rec;
    logic         rdy;
    if (rst_n && out_valid && out_ready) begin
      if (postfix_q.size() == 0) begin
        log_mismatch($sformatf("unexpected transfer sym %h has %b end %b status %0d",
                               out_symbol, out_has_symbol, out_end_of_expr, out_status));
      end else begin
        exp_rec = postfix_q.pop_front();
        if (out_symbol !== exp_rec.sym || out_has_symbol !== exp_rec.has ||
            out_end_of_expr !== exp_rec.eoe || out_status !== exp_rec.st)
          log_mismatch($sformatf(
            "exp sym %h has %b end %b status %0d, got sym %h has %b end %b status %0d",
            exp_rec.sym, exp_rec.has, exp_rec.eoe, exp_rec.st,
            out_symbol, out_has_symbol, out_end_of_expr, out_status));
      end
    end
    // switch stall pattern now and then
    if (mode_left == 0) begin
      ready_mode <= $urandom_range(3);
      mode_left  <= $urandom_range(150, 40);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_phase <= stall_phase + 4'd1;
    case (ready_mode)
      0:       rdy = 1'b1;
      1:       rdy = ($urandom_range(1) == 0);
      2:       rdy = ($urandom_range(3) == 0);
      default: rdy = (stall_phase < 4'd3);
    endcase
    out_ready <= rdy;
  end

  initial begin
    int   n_directed;
    int   pick;
    int   cycles;
    logic timed_out;

    // Directed: precedence, all bracket kinds, error cases, empty ends
    add_expr("A+B*c");
    add_expr("(A-B]/z");
    add_expr("}");
    add_expr(")[");
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b1);
    add_expr("{z");
    add_expr("a/b*C");
    n_directed = infix_q.size();

    // Random: one overflow up front, then mostly balanced expressions
    gen_overflow();
    while (infix_q.size() - n_directed < RAND_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 5) gen_overflow();
      else if (pick < 80) gen_balanced();
      else gen_broken();
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Sample mid-cycle so driver and monitor updates have settled
    cycles = 0;
    timed_out = 1'b0;
    while ((infix_q.size() > 0 || in_valid || postfix_q.size() > 0) && !timed_out) begin
      @(negedge clk);
      cycles++;
      if (cycles >= LIMIT_CYCLES) timed_out = 1'b1;
    end
    if (!timed_out) repeat (TAIL_CYCLES) @(negedge clk);

    if (!timed_out && mismatch_cnt == 0 && postfix_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/i2p_pkg.sv
sv/i2p_stack.sv
sv/infix_to_postfix_converter.sv
test/infix_to_postfix_converter_tb.sv
